>>> src/mcg_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_pkg
// Shared types and constants of the multi-click gesture detector.
// ---------------------------------------------------------------------------
package mcg_pkg;

    localparam int NUM_KEYS = 6;
    localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    localparam int TIMER_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_DELAY  = 2'd1;

    localparam logic [TIMER_W-1:0] DEFAULT_DELAY_MS = 10'd400;
    localparam logic [1:0]         MAX_COUNT        = 2'd3;

    localparam logic [2:0] ACT_CLEAR  = 3'd0;
    localparam logic [2:0] ACT_SINGLE = 3'd5;

    // One entry of per-key state.
    typedef struct packed {
        logic [1:0]         cnt;
        logic [TIMER_W-1:0] left;
        logic               armed;
        logic               pending;
    } t_entry;

    // Request from the sequencer to the output stage.
    typedef struct packed {
        logic       push;
        logic       flush;
        logic [2:0] key;
        logic [2:0] code;
    } t_out_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRESS,
        ST_CLR_RD,
        ST_CLR_MOD,
        ST_KEY_RD,
        ST_KEY_MOD,
        ST_FLUSH
    } t_state;

endpackage

>>> src/mcg_state_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_state_ram
// Per-key state memory, one write and one registered read port. Entries
// that were never written since reset read as zero.
// ---------------------------------------------------------------------------
module mcg_state_ram import mcg_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [KEY_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic             i_re,
    input  logic [KEY_W-1:0] i_raddr,
    output t_entry           o_rdata
);

    t_entry               r_mem [NUM_KEYS];
    logic [NUM_KEYS-1:0]  r_valid;
    t_entry               r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mcg_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcg_out_stage
// Holds the newest result back by one so that the final result of a tick
// can carry tlast, and drives the master stream from an output register.
// ---------------------------------------------------------------------------
module mcg_out_stage import mcg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_out_req   i_req,
    output logic       o_rdy,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [2:0] key_index, [5:3] action_code
    output logic       m_axis_tlast
);

    logic       r_hold_v, n_hold_v;
    logic [2:0] r_hold_key, n_hold_key;
    logic [2:0] r_hold_code, n_hold_code;
    logic       r_out_v, n_out_v;
    logic [2:0] r_out_key, n_out_key;
    logic [2:0] r_out_code, n_out_code;
    logic       r_out_last, n_out_last;
    logic       can_move;

    always_comb begin
        can_move    = !r_out_v || m_axis_tready;
        o_rdy       = !r_hold_v || can_move;
        n_hold_v    = r_hold_v;
        n_hold_key  = r_hold_key;
        n_hold_code = r_hold_code;
        n_out_v     = r_out_v && !m_axis_tready;
        n_out_key   = r_out_key;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;

        // A held result moves out once the next one arrives or the tick ends.
        if (r_hold_v && can_move && (i_req.push || i_req.flush)) begin
            n_out_v    = 1'b1;
            n_out_key  = r_hold_key;
            n_out_code = r_hold_code;
            n_out_last = i_req.flush;
        end
        if (i_req.push && o_rdy) begin
            n_hold_v    = 1'b1;
            n_hold_key  = i_req.key;
            n_hold_code = i_req.code;
        end else if (i_req.flush && o_rdy) begin
            n_hold_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_hold_v <= n_hold_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_key  <= n_hold_key;
        r_hold_code <= n_hold_code;
        r_out_key   <= n_out_key;
        r_out_code  <= n_out_code;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {2'b00, r_out_code, r_out_key};
    assign m_axis_tlast  = r_out_last;

endmodule

>>> src/multi_click_gesture_detector.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_click_gesture_detector
// Counts presses per key inside a retriggerable click window and reports
// single, double and triple gestures, then clears pending keys after a
// shared delay.
// ---------------------------------------------------------------------------
//  Channel   Dir  Transfer          Payload
//  s_axis    in   tvalid & tready   tdata[2:0] key, tuser[0] mode (1 = tick)
//  m_axis    out  tvalid & tready   tdata[2:0] key_index, [5:3] action_code,
//                                   tlast on the final result of a tick
//  cfg       in   i_cfg_we          i_cfg_idx register, i_cfg_data value
//
//  A press reads its key's entry and writes it back updated. A tick makes a
//  read-modify-write pass over every key in the state memory, a read state
//  and a modify state for each key, preceded by a clearing pass of the same
//  kind when the clear timer expires; output stalls can hold up either pass.
//  Reset is synchronous; the state memory reads as zero until written, so
//  no clearing pass is needed. Input is taken only between items.
// ---------------------------------------------------------------------------
module multi_click_gesture_detector import mcg_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [2:0] key
    input  logic [0:0]           s_axis_tuser,   // [0] mode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [2:0] key_index, [5:3] action_code
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [TIMER_W-1:0]   i_cfg_data
);

    localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

    t_state             r_state, n_state;
    logic [KEY_W-1:0]   r_idx, n_idx;
    logic [TIMER_W-1:0] r_click_window;
    logic [TIMER_W-1:0] r_clear_delay;
    logic [TIMER_W-1:0] r_clear_left, n_clear_left;
    logic               r_clear_armed, n_clear_armed;

    logic               ram_we;
    logic [KEY_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [KEY_W-1:0]   ram_raddr;
    t_entry             rd;
    t_out_req           req;
    logic               out_rdy;
    logic [2:0]         in_key;
    logic               in_tick;

    assign in_key  = s_axis_tdata[2:0];
    assign in_tick = s_axis_tuser[0];

    mcg_state_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    mcg_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_rdy         (out_rdy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_click_window <= DEFAULT_DELAY_MS;
            r_clear_delay  <= DEFAULT_DELAY_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CLICK_WINDOW: r_click_window <= i_cfg_data;
                CFG_CLEAR_DELAY:  r_clear_delay  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_idx         <= '0;
            r_clear_left  <= '0;
            r_clear_armed <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_idx         <= n_idx;
            r_clear_left  <= n_clear_left;
            r_clear_armed <= n_clear_armed;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_clear_left  = r_clear_left;
        n_clear_armed = r_clear_armed;
        ram_we        = 1'b0;
        ram_waddr     = r_idx;
        ram_wdata     = rd;
        ram_re        = 1'b0;
        ram_raddr     = r_idx;
        req           = '0;
        req.key       = 3'(r_idx);
        s_axis_tready = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (!in_tick) begin
                        // Presses for keys beyond the key count are dropped.
                        if (int'(in_key) < NUM_KEYS) begin
                            ram_re    = 1'b1;
                            ram_raddr = KEY_W'(in_key);
                            n_idx     = KEY_W'(in_key);
                            n_state   = ST_PRESS;
                        end
                    end else begin
                        n_idx = '0;
                        if (r_clear_armed && (r_clear_left <= TIMER_W'(1))) begin
                            n_clear_left  = '0;
                            n_clear_armed = 1'b0;
                            n_state       = ST_CLR_RD;
                        end else begin
                            if (r_clear_armed) begin
                                n_clear_left = r_clear_left - TIMER_W'(1);
                            end
                            n_state = ST_KEY_RD;
                        end
                    end
                end
            end

            ST_PRESS: begin
                ram_we          = 1'b1;
                ram_wdata.cnt   = (rd.cnt < MAX_COUNT) ? rd.cnt + 2'd1 : rd.cnt;
                ram_wdata.left  = r_click_window;
                ram_wdata.armed = 1'b1;
                n_state         = ST_IDLE;
            end

            ST_CLR_RD: begin
                ram_re  = 1'b1;
                n_state = ST_CLR_MOD;
            end

            ST_CLR_MOD: begin
                if (rd.pending) begin
                    req.push = 1'b1;
                    req.code = ACT_CLEAR;
                end
                if (!rd.pending || out_rdy) begin
                    if (rd.pending) begin
                        ram_we            = 1'b1;
                        ram_wdata.pending = 1'b0;
                    end
                    if (r_idx == LAST_KEY) begin
                        n_idx   = '0;
                        n_state = ST_KEY_RD;
                    end else begin
                        n_idx   = r_idx + KEY_W'(1);
                        n_state = ST_CLR_RD;
                    end
                end
            end

            ST_KEY_RD: begin
                ram_re  = 1'b1;
                n_state = ST_KEY_MOD;
            end

            ST_KEY_MOD: begin
                if (rd.armed && (rd.left <= TIMER_W'(1)) && (rd.cnt != 2'd0)) begin
                    req.push = 1'b1;
                    req.code = ACT_SINGLE + 3'(rd.cnt) - 3'd1;
                end
                if (!req.push || out_rdy) begin
                    if (rd.armed) begin
                        ram_we = 1'b1;
                        if (rd.left <= TIMER_W'(1)) begin
                            ram_wdata.cnt   = 2'd0;
                            ram_wdata.left  = '0;
                            ram_wdata.armed = 1'b0;
                            if (rd.cnt != 2'd0) begin
                                ram_wdata.pending = 1'b1;
                                n_clear_left      = r_clear_delay;
                                n_clear_armed     = 1'b1;
                            end
                        end else begin
                            ram_wdata.left = rd.left - TIMER_W'(1);
                        end
                    end
                    if (r_idx == LAST_KEY) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_idx   = r_idx + KEY_W'(1);
                        n_state = ST_KEY_RD;
                    end
                end
            end

            ST_FLUSH: begin
                req.flush = 1'b1;
                if (out_rdy) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
